### rtl/tt_pkg.sv
package tt_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned NowW   = 63;
  localparam int unsigned IdW    = 16;
  localparam int unsigned DelayW = 48;
  localparam int unsigned PortW  = 32;
  localparam int unsigned DlW    = 64;
  localparam int unsigned AgeW   = 32;

  typedef enum logic [1:0] {
    ModeTick   = 2'd0,
    ModeSet    = 2'd1,
    ModeCancel = 2'd2,
    ModeRsvd   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StEmit,
    StInsert,
    StStatScan,
    StStatus
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat, clear scan state
    logic scan_clr;   // restart a scan pass
    logic scan_step;  // examine one entry
    logic expire;     // emit best and drop it
    logic insert;     // arm new entry if allowed
    logic status;     // emit closing status
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // last entry examined this cycle
    logic found;      // a due entry was selected in the pass
    logic is_set;
    logic is_cancel;
  } stat_t;

endpackage

### rtl/tt_ctrl.sv
module tt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tt_pkg::stat_t stat_i,
  output tt_pkg::cmd_t  cmd_o,
  output logic          busy_o
);
  import tt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:     if (start_i) state_d = StScan;
      StScan: begin
        if (stat_i.scan_done) begin
          if (stat_i.is_cancel) state_d = StStatScan;
          else if (stat_i.found) state_d = StEmit;
          else if (stat_i.is_set) state_d = StInsert;
          else state_d = StStatScan;
        end
      end
      StEmit:     state_d = StScan;
      StInsert:   state_d = StStatScan;
      StStatScan: if (stat_i.scan_done) state_d = StStatus;
      StStatus:   state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      StScan:     cmd_o.scan_step = 1'b1;
      StEmit: begin
        cmd_o.expire   = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      StInsert: begin
        cmd_o.insert   = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      StStatScan: cmd_o.scan_step = 1'b1;
      StStatus:   cmd_o.status    = 1'b1;
      default:    busy_o = 1'b1;
    endcase
  end

endmodule

### rtl/tt_dp.sv
module tt_dp #(
  parameter int unsigned Entries = tt_pkg::EntriesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tt_pkg::cmd_t              cmd_i,
  output tt_pkg::stat_t             stat_o,
  input  logic [1:0]                mode_i,
  input  logic [tt_pkg::NowW-1:0]   now_i,
  input  logic [tt_pkg::IdW-1:0]    timer_id_i,
  input  logic [tt_pkg::DelayW-1:0] delay_i,
  input  logic [tt_pkg::PortW-1:0]  port_i,
  output logic                      strobe_o,
  output logic                      kind_o,
  output logic [tt_pkg::IdW-1:0]    expired_id_o,
  output logic [tt_pkg::PortW-1:0]  reply_port_o,
  output logic [tt_pkg::NowW-1:0]   lateness_o,
  output logic [tt_pkg::NowW-1:0]   next_wait_o,
  output logic                      idle_o,
  output logic                      dropped_o,
  output logic                      last_o,
  output logic [Entries-1:0]        valid_o
);
  import tt_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [DlW-1:0]   dl_q   [Entries];
  logic [IdW-1:0]   id_q   [Entries];
  logic [PortW-1:0] port_q [Entries];
  logic [AgeW-1:0]  age_q  [Entries];
  logic [Entries-1:0] valid_q;
  logic [AgeW-1:0]  cnt_q;

  logic [1:0]        mode_q;
  logic [NowW-1:0]   now_q;
  logic [IdW-1:0]    tid_q;
  logic [DelayW-1:0] delay_q;
  logic [PortW-1:0]  port_in_q;

  // scan state
  logic [IdxW:0]    ptr_q;
  logic             best_v_q;
  logic [IdxW-1:0]  best_q;
  logic [DlW-1:0]   best_dl_q;
  logic [AgeW-1:0]  best_age_q;
  logic             hit_q;     // id already armed
  logic             free_v_q;
  logic [IdxW-1:0]  free_q;
  logic             drop_q;

  logic [IdxW-1:0]  idx;
  logic [DlW-1:0]   now64;
  logic             ev, due, better, sel;

  assign idx   = ptr_q[IdxW-1:0];
  assign now64 = {1'b0, now_q};
  assign ev    = valid_q[idx];
  assign due   = dl_q[idx] <= now64;
  assign better = !best_v_q || (dl_q[idx] < best_dl_q) ||
                  (dl_q[idx] == best_dl_q && age_q[idx] < best_age_q);

  // status pass picks earliest of all, expire pass earliest due with age tiebreak
  logic status_phase_q;
  assign sel = ev && better && (status_phase_q || (due && mode_q != ModeCancel));

  assign stat_o.scan_done = cmd_i.scan_step && (ptr_q == (IdxW+1)'(Entries - 1));
  assign stat_o.found     = best_v_q || sel;
  assign stat_o.is_set    = mode_q == ModeSet;
  assign stat_o.is_cancel = mode_q == ModeCancel;
  assign valid_o = valid_q;

  logic [DlW-1:0] new_dl;
  assign new_dl = now64 + {{(DlW-DelayW){1'b0}}, delay_q};

  logic [DlW-1:0] wait_full;
  assign wait_full = best_dl_q - now64;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i; now_q <= now_i; tid_q <= timer_id_i;
      delay_q <= delay_i; port_in_q <= port_i;
    end
    if (cmd_i.scan_step) begin
      if (sel) begin
        best_q <= idx; best_dl_q <= dl_q[idx]; best_age_q <= age_q[idx];
      end
      if (!ev && !free_v_q) free_q <= idx;
    end
    if (cmd_i.insert && mode_q == ModeSet && !hit_q && free_v_q) begin
      dl_q[free_q] <= new_dl; id_q[free_q] <= tid_q;
      port_q[free_q] <= port_in_q; age_q[free_q] <= cnt_q;
    end
    if (cmd_i.expire) begin
      expired_id_o <= id_q[best_q];
      reply_port_o <= port_q[best_q];
      lateness_o   <= now_q - best_dl_q[NowW-1:0];
    end else begin
      expired_id_o <= '0; reply_port_o <= '0; lateness_o <= '0;
    end
    if (cmd_i.status) begin
      next_wait_o <= (best_v_q && best_dl_q > now64)
                     ? (wait_full[DlW-1] ? {NowW{1'b1}} : wait_full[NowW-1:0]) : '0;
      idle_o      <= ~best_v_q;
      dropped_o   <= drop_q;
    end else begin
      next_wait_o <= '0; idle_o <= 1'b0; dropped_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; cnt_q <= '0; ptr_q <= '0; best_v_q <= 1'b0;
      hit_q <= 1'b0; free_v_q <= 1'b0; drop_q <= 1'b0; status_phase_q <= 1'b0;
      strobe_o <= 1'b0; kind_o <= 1'b0; last_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.expire || cmd_i.status;
      kind_o   <= cmd_i.status;
      last_o   <= cmd_i.status;
      if (cmd_i.load) begin
        ptr_q <= '0; best_v_q <= 1'b0; hit_q <= 1'b0; free_v_q <= 1'b0;
        drop_q <= 1'b0; status_phase_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        ptr_q <= stat_o.scan_done ? '0 : ptr_q + 1'b1;
        if (sel) best_v_q <= 1'b1;
        if (ev && id_q[idx] == tid_q) hit_q <= 1'b1;
        if (!ev) free_v_q <= 1'b1;
        // cancel drops the matching entry during its pass
        if (!status_phase_q && mode_q == ModeCancel && ev && id_q[idx] == tid_q)
          valid_q[idx] <= 1'b0;
      end
      if (cmd_i.scan_clr) begin
        ptr_q <= '0; best_v_q <= 1'b0; hit_q <= 1'b0; free_v_q <= 1'b0;
      end
      if (cmd_i.expire) valid_q[best_q] <= 1'b0;
      if (cmd_i.insert) begin
        status_phase_q <= 1'b1;
        if (mode_q == ModeSet && !hit_q) begin
          if (free_v_q) begin
            valid_q[free_q] <= 1'b1;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            drop_q <= 1'b1;
          end
        end
      end
      // tick or reserved mode with nothing due, and cancel, go straight to the status pass
      if (cmd_i.scan_step && stat_o.scan_done && !status_phase_q &&
          (mode_q == ModeCancel || (!stat_o.found && mode_q != ModeSet))) begin
        status_phase_q <= 1'b1;
        best_v_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/timeout_table.sv
// channel   | signals                                      | beat taken when
// ----------+----------------------------------------------+------------------
// command   | start_i, mode/now/timer_id/delay/port_i      | start_i && !busy_o
// result    | result_valid_o, kind..last_o                 | result_valid_o
//
// Tick/set emit an expiry beat per due entry, rescanning after each; a set then tries to
// insert. A final pass finds the next deadline for the status beat; each pass examines
// one entry a cycle. Expiry passes pick the earliest due entry, the status pass the
// earliest armed one. Reset clears valid bits, counter, FSM, scan state and result flags.
// Results cannot be stalled; busy_o drops in the cycle the status beat is out.
module timeout_table #(
  parameter int unsigned ENTRIES = tt_pkg::EntriesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                mode_i,
  input  logic [tt_pkg::NowW-1:0]   now_i,
  input  logic [tt_pkg::IdW-1:0]    timer_id_i,
  input  logic [tt_pkg::DelayW-1:0] delay_i,
  input  logic [tt_pkg::PortW-1:0]  port_i,
  output logic                      result_valid_o,
  output logic                      kind_o,
  output logic [tt_pkg::IdW-1:0]    expired_id_o,
  output logic [tt_pkg::PortW-1:0]  reply_port_o,
  output logic [tt_pkg::NowW-1:0]   lateness_o,
  output logic [tt_pkg::NowW-1:0]   next_wait_o,
  output logic                      idle_o,
  output logic                      dropped_o,
  output logic                      last_o
);
  import tt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [ENTRIES-1:0] valid;

  tt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  tt_dp #(.Entries(ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .now_i, .timer_id_i, .delay_i, .port_i,
    .strobe_o(result_valid_o), .kind_o, .expired_id_o, .reply_port_o,
    .lateness_o, .next_wait_o, .idle_o, .dropped_o, .last_o,
    .valid_o(valid)
  );

  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == kind_o)) else $error("last without status");
  a_status_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o) else $error("busy after status");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && idle_o) |-> valid == '0) else $error("idle with armed entry");
  a_expire_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.expire |=> $countones(valid) == $countones($past(valid)) - 1)
    else $error("expiry kept entry");

endmodule
